// ===== design/ptx_pkg.sv =====
package ptx_pkg;

  localparam int DIM       = 4;
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 4;
  localparam int Q_W       = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * Q_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int TOP_W     = SUM_W - FRAC_W - Q_W + 1;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [REG_W-1:0]         reg_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_W - 1);
  localparam q_t   Q_MAX      = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t   Q_MIN      = {1'b1, {(Q_W-1){1'b0}}};

  // identity matrix
  localparam reg_t REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

endpackage

// ===== design/ptx_regs.sv =====
module ptx_regs
  import ptx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  input  cfg_idx_t cfg_index,
  input  reg_t     cfg_data,
  output q_t       mat [DIM][DIM]
);

  reg_t regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= REG_RESET[i];
    end else if (cfg_valid && (cfg_index < cfg_idx_t'(NUM_REGS))) begin
      regs[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      assign mat[r][c] = q_t'(regs[r*2 + c/2][(c%2)*Q_W +: Q_W]);
    end
  end

endmodule

// ===== design/ptx_mul.sv =====
module ptx_mul
  import ptx_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  q_t    col [DIM],
  input  q_t    mat [DIM][DIM],
  output prod_t prod [DIM][DIM]
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++)
        for (int c = 0; c < DIM; c++)
          prod[r][c] <= prod_t'(mat[r][c]) * prod_t'(col[c]);
    end
  end

endmodule

// ===== design/ptx_add.sv =====
module ptx_add
  import ptx_pkg::*;
(
  input  logic  clk,
  input  logic  en_pair,
  input  logic  en_sum,
  input  prod_t prod [DIM][DIM],
  output sum_t  sum [DIM]
);

  pair_t pair [DIM][2];

  always_ff @(posedge clk) begin
    if (en_pair) begin
      for (int r = 0; r < DIM; r++) begin
        pair[r][0] <= pair_t'(prod[r][0]) + pair_t'(prod[r][1]);
        pair[r][1] <= pair_t'(prod[r][2]) + pair_t'(prod[r][3]);
      end
    end
  end

  // rounding offset folded into the final add
  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int r = 0; r < DIM; r++)
        sum[r] <= sum_t'(pair[r][0]) + sum_t'(pair[r][1]) + ROUND_HALF;
    end
  end

endmodule

// ===== design/ptx_sat.sv =====
module ptx_sat
  import ptx_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  sum_t sum [DIM],
  output q_t   res [DIM],
  output logic saturated
);

  q_t             res_next [DIM];
  logic [DIM-1:0] clip;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      logic [TOP_W-1:0] top;
      top     = sum[r][SUM_W-1 -: TOP_W];
      clip[r] = !((&top) || !(|top));
      if (!clip[r])        res_next[r] = q_t'(sum[r][FRAC_W +: Q_W]);
      else if (sum[r][SUM_W-1]) res_next[r] = Q_MIN;
      else                 res_next[r] = Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res       <= res_next;
      saturated <= |clip;
    end
  end

endmodule

// ===== design/point_transform_4x4.sv =====
// Throughput: one point per cycle unless the output stalls; stages are multiply,
// pair add, sum and round, saturate. Bubbles are squeezed out under output stall.
// Reset (rst, synchronous): pipeline emptied, matrix set to identity.
module point_transform_4x4
  import ptx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  reg_t     cfg_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  q_t       x_in,
  input  q_t       y_in,
  input  q_t       z_in,
  input  q_t       w_in,
  input  logic     last_point,
  output logic     out_valid,
  input  logic     out_stall,
  output q_t       x_out,
  output q_t       y_out,
  output q_t       z_out,
  output q_t       w_out,
  output logic     last_out,
  output logic     saturated
);

  q_t    mat  [DIM][DIM];
  q_t    col  [DIM];
  prod_t prod [DIM][DIM];
  sum_t  sum  [DIM];
  q_t    res  [DIM];

  logic v1, v2, v3;
  logic lst1, lst2, lst3;
  logic en1, en2, en3, en4;

  assign cfg_ready = 1'b1;

  assign en4 = !out_valid || !out_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  assign col[0] = x_in;
  assign col[1] = y_in;
  assign col[2] = z_in;
  assign col[3] = w_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) lst1 <= last_point;
    if (en2) lst2 <= lst1;
    if (en3) lst3 <= lst2;
    if (en4) last_out <= lst3;
  end

  ptx_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  ptx_mul u_mul (
    .clk  (clk),
    .en   (en1),
    .col  (col),
    .mat  (mat),
    .prod (prod)
  );

  ptx_add u_add (
    .clk     (clk),
    .en_pair (en2),
    .en_sum  (en3),
    .prod    (prod),
    .sum     (sum)
  );

  ptx_sat u_sat (
    .clk       (clk),
    .en        (en4),
    .sum       (sum),
    .res       (res),
    .saturated (saturated)
  );

  assign x_out = res[0];
  assign y_out = res[1];
  assign z_out = res[2];
  assign w_out = res[3];

endmodule

// ===== design/ptx_checker.sv =====
module ptx_checker
  import ptx_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input q_t       x_out,
  input q_t       y_out,
  input q_t       z_out,
  input q_t       w_out,
  input logic     saturated
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // input only backs up when all four stages hold data behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in pipeline");

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (x_out == Q_MAX || x_out == Q_MIN || y_out == Q_MAX || y_out == Q_MIN ||
       z_out == Q_MAX || z_out == Q_MIN || w_out == Q_MAX || w_out == Q_MIN))
    else $error("saturated flag without a clipped row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(x_out) && $stable(w_out)))
    else $error("stalled result changed");

endmodule

bind point_transform_4x4 ptx_checker u_chk (.*);
